>>> rtl/core/tpu_pkg.sv
`timescale 1ns / 1ps

package tpu_pkg;

    // Fixed field widths of the item channels
    localparam int CMD_W        = 4;
    localparam int REG_FIELD_W  = 4;
    localparam int ADDR_FIELD_W = 16;
    localparam int TAG_FIELD_W  = 8;

    // Internal register index width, wide enough for PC_INDEX and LR_INDEX up to 63
    localparam int RIDX_W = 6;

    // Parameter defaults
    localparam int NUM_REGS_DEF      = 16;
    localparam int MEM_ADDR_BITS_DEF = 16;
    localparam int TAG_BITS_DEF      = 8;
    localparam int PC_INDEX_DEF      = 15;
    localparam int LR_INDEX_DEF      = 14;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD      = 4'd0,
        CMD_STORE     = 4'd1,
        CMD_MOV_REG   = 4'd2,
        CMD_MOV_IMM   = 4'd3,
        CMD_ARITH1    = 4'd4,
        CMD_ARITH2    = 4'd5,
        CMD_LINK      = 4'd6,
        CMD_LINK_JUMP = 4'd7,
        CMD_JUMP      = 4'd8,
        CMD_NONE      = 4'd9,
        CMD_RD_REG    = 4'd10,
        CMD_WR_REG    = 4'd11,
        CMD_RD_MEM    = 4'd12,
        CMD_WR_MEM    = 4'd13
    } t_cmd;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ_A,
        ST_CAP_A,
        ST_CAP_B,
        ST_LINK,
        ST_READ_J,
        ST_CAP_J,
        ST_WRITE
    } t_state;

    typedef enum logic [1:0] {
        RSEL_RD,
        RSEL_RA,
        RSEL_RB,
        RSEL_PC
    } t_rsel;

    typedef enum logic [2:0] {
        WSEL_NONE,
        WSEL_RD,
        WSEL_LR,
        WSEL_PC,
        WSEL_MEM
    } t_wsel;

    typedef enum logic [1:0] {
        CAP_NONE,
        CAP_OR_REG,
        CAP_OR_MEM,
        CAP_LOAD_REG
    } t_cap;

    typedef struct packed {
        logic  latch;
        logic  clr_step;
        logic  reg_rd;
        t_rsel rsel;
        t_cap  cap;
        t_wsel wsel;
        logic  out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             clr_last;
        logic             out_free;
    } t_dp_stat;

endpackage

>>> rtl/core/tpu_if.sv
`timescale 1ns / 1ps

interface tpu_in_if;
    import tpu_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        cmd;
    logic [REG_FIELD_W-1:0]  dst_reg;
    logic [REG_FIELD_W-1:0]  src_a_reg;
    logic [REG_FIELD_W-1:0]  src_b_reg;
    logic [ADDR_FIELD_W-1:0] mem_address;
    logic [TAG_FIELD_W-1:0]  tag_value;

    modport source (
        output valid, cmd, dst_reg, src_a_reg, src_b_reg, mem_address, tag_value,
        input  ready
    );
    modport sink (
        input  valid, cmd, dst_reg, src_a_reg, src_b_reg, mem_address, tag_value,
        output ready
    );
endinterface

interface tpu_out_if;
    import tpu_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [TAG_FIELD_W-1:0] tag_out;

    modport source (
        output valid, tag_out,
        input  ready
    );
    modport sink (
        input  valid, tag_out,
        output ready
    );
endinterface

>>> rtl/core/tpu_ram.sv
`timescale 1ns / 1ps

module tpu_ram #(
    parameter int unsigned     WIDTH = 8,
    parameter longint unsigned DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/core/tpu_ctrl.sv
`timescale 1ns / 1ps

module tpu_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic [tpu_pkg::CMD_W-1:0] i_in_cmd,
    input  tpu_pkg::t_dp_stat        i_stat,
    output logic                     o_in_ready,
    output tpu_pkg::t_dp_cmd         o_cmd
);
    import tpu_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_stat.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_cmd inside {CMD_LOAD, CMD_STORE, CMD_MOV_REG, CMD_ARITH1,
                                         CMD_ARITH2, CMD_LINK, CMD_LINK_JUMP, CMD_JUMP,
                                         CMD_RD_REG, CMD_RD_MEM}) begin
                        n_state = ST_READ_A;
                    end else begin
                        n_state = ST_WRITE;
                    end
                end
            end
            ST_READ_A: n_state = ST_CAP_A;
            ST_CAP_A: begin
                if (i_stat.cmd == CMD_ARITH2) begin
                    n_state = ST_CAP_B;
                end else if (i_stat.cmd == CMD_LINK_JUMP) begin
                    n_state = ST_LINK;
                end else begin
                    n_state = ST_WRITE;
                end
            end
            ST_CAP_B:  n_state = ST_WRITE;
            ST_LINK:   n_state = ST_READ_J;
            ST_READ_J: n_state = ST_CAP_J;
            ST_CAP_J:  n_state = ST_WRITE;
            ST_WRITE: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default:   n_state = ST_CLEAR;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd.latch    = 1'b0;
        o_cmd.clr_step = 1'b0;
        o_cmd.reg_rd   = 1'b0;
        o_cmd.rsel     = RSEL_RA;
        o_cmd.cap      = CAP_NONE;
        o_cmd.wsel     = WSEL_NONE;
        o_cmd.out_load = 1'b0;
        case (r_state)
            ST_CLEAR: o_cmd.clr_step = 1'b1;
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            ST_READ_A: begin
                // Memory reads need no command: the address register drives the port
                if (i_stat.cmd inside {CMD_STORE, CMD_RD_REG}) begin
                    o_cmd.reg_rd = 1'b1;
                    o_cmd.rsel   = RSEL_RD;
                end else if (i_stat.cmd inside {CMD_LINK, CMD_LINK_JUMP}) begin
                    o_cmd.reg_rd = 1'b1;
                    o_cmd.rsel   = RSEL_PC;
                end else if (!(i_stat.cmd inside {CMD_LOAD, CMD_RD_MEM})) begin
                    o_cmd.reg_rd = 1'b1;
                    o_cmd.rsel   = RSEL_RA;
                end
            end
            ST_CAP_A: begin
                if (i_stat.cmd inside {CMD_LOAD, CMD_RD_MEM}) begin
                    o_cmd.cap = CAP_OR_MEM;
                end else begin
                    o_cmd.cap = CAP_OR_REG;
                end
                if (i_stat.cmd == CMD_ARITH2) begin
                    o_cmd.reg_rd = 1'b1;
                    o_cmd.rsel   = RSEL_RB;
                end
            end
            ST_CAP_B: o_cmd.cap = CAP_OR_REG;
            ST_LINK:  o_cmd.wsel = WSEL_LR;
            ST_READ_J: begin
                o_cmd.reg_rd = 1'b1;
                o_cmd.rsel   = RSEL_RA;
            end
            ST_CAP_J: o_cmd.cap = CAP_LOAD_REG;
            ST_WRITE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    case (i_stat.cmd)
                        CMD_LOAD, CMD_MOV_REG, CMD_MOV_IMM, CMD_ARITH1, CMD_ARITH2,
                        CMD_WR_REG:                     o_cmd.wsel = WSEL_RD;
                        CMD_LINK:                       o_cmd.wsel = WSEL_LR;
                        CMD_LINK_JUMP, CMD_JUMP:        o_cmd.wsel = WSEL_PC;
                        CMD_STORE, CMD_WR_MEM:          o_cmd.wsel = WSEL_MEM;
                        default:                        o_cmd.wsel = WSEL_NONE;
                    endcase
                end
            end
            default: ;
        endcase
    end
endmodule

>>> rtl/core/tpu_dp.sv
`timescale 1ns / 1ps

module tpu_dp #(
    parameter int NUM_REGS      = tpu_pkg::NUM_REGS_DEF,
    parameter int MEM_ADDR_BITS = tpu_pkg::MEM_ADDR_BITS_DEF,
    parameter int TAG_BITS      = tpu_pkg::TAG_BITS_DEF,
    parameter int PC_INDEX      = tpu_pkg::PC_INDEX_DEF,
    parameter int LR_INDEX      = tpu_pkg::LR_INDEX_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tpu_pkg::t_dp_cmd                 i_cmd,
    output tpu_pkg::t_dp_stat                o_stat,
    input  logic [tpu_pkg::CMD_W-1:0]        i_in_cmd,
    input  logic [tpu_pkg::REG_FIELD_W-1:0]  i_dst_reg,
    input  logic [tpu_pkg::REG_FIELD_W-1:0]  i_src_a_reg,
    input  logic [tpu_pkg::REG_FIELD_W-1:0]  i_src_b_reg,
    input  logic [tpu_pkg::ADDR_FIELD_W-1:0] i_mem_address,
    input  logic [tpu_pkg::TAG_FIELD_W-1:0]  i_tag_value,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [tpu_pkg::TAG_FIELD_W-1:0]  o_tag_out
);
    import tpu_pkg::*;

    localparam int RA_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam logic [RIDX_W:0]       NREG_LIM = (RIDX_W + 1)'(NUM_REGS);
    localparam logic [RIDX_W-1:0]     PC_IDX   = RIDX_W'(PC_INDEX);
    localparam logic [RIDX_W-1:0]     LR_IDX   = RIDX_W'(LR_INDEX);
    localparam longint unsigned       MEM_DEPTH = longint'(1) << MEM_ADDR_BITS;

    // Latched item
    logic [CMD_W-1:0]         r_cmd;
    logic [REG_FIELD_W-1:0]   r_rd;
    logic [REG_FIELD_W-1:0]   r_ra;
    logic [REG_FIELD_W-1:0]   r_rb;
    logic [MEM_ADDR_BITS-1:0] r_addr;
    logic [TAG_BITS-1:0]      r_acc;

    logic [NUM_REGS-1:0]      r_valid;
    logic                     r_rd_ok;
    logic [MEM_ADDR_BITS-1:0] r_clr_cnt;
    logic                     r_out_valid;
    logic [TAG_BITS-1:0]      r_out_tag;

    logic [RIDX_W-1:0]        rd_idx;
    logic                     rd_in_range;
    logic [RIDX_W-1:0]        wr_idx;
    logic                     wr_in_range;
    logic                     reg_we;
    logic [TAG_BITS-1:0]      reg_q;
    logic                     mem_we;
    logic [MEM_ADDR_BITS-1:0] mem_waddr;
    logic [TAG_BITS-1:0]      mem_wdata;
    logic [TAG_BITS-1:0]      mem_q;
    logic [TAG_BITS-1:0]      reg_tag;
    logic                     out_free;

    // Register tag read index
    always_comb begin
        case (i_cmd.rsel)
            RSEL_RD: rd_idx = RIDX_W'(r_rd);
            RSEL_RA: rd_idx = RIDX_W'(r_ra);
            RSEL_RB: rd_idx = RIDX_W'(r_rb);
            RSEL_PC: rd_idx = PC_IDX;
            default: rd_idx = RIDX_W'(r_ra);
        endcase
    end
    assign rd_in_range = {1'b0, rd_idx} < NREG_LIM;

    // Register tag write index
    always_comb begin
        case (i_cmd.wsel)
            WSEL_RD: wr_idx = RIDX_W'(r_rd);
            WSEL_LR: wr_idx = LR_IDX;
            WSEL_PC: wr_idx = PC_IDX;
            default: wr_idx = RIDX_W'(r_rd);
        endcase
    end
    assign wr_in_range = {1'b0, wr_idx} < NREG_LIM;
    assign reg_we = (i_cmd.wsel == WSEL_RD || i_cmd.wsel == WSEL_LR || i_cmd.wsel == WSEL_PC)
                    && wr_in_range;

    assign mem_we    = i_cmd.clr_step || (i_cmd.wsel == WSEL_MEM);
    assign mem_waddr = i_cmd.clr_step ? r_clr_cnt : r_addr;
    assign mem_wdata = i_cmd.clr_step ? '0 : r_acc;

    tpu_ram #(
        .WIDTH (TAG_BITS),
        .DEPTH (longint'(NUM_REGS))
    ) u_reg_ram (
        .i_clk   (i_clk),
        .i_we    (reg_we),
        .i_waddr (wr_idx[RA_W-1:0]),
        .i_wdata (r_acc),
        .i_raddr (rd_idx[RA_W-1:0]),
        .o_rdata (reg_q)
    );

    tpu_ram #(
        .WIDTH (TAG_BITS),
        .DEPTH (MEM_DEPTH)
    ) u_mem_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_addr),
        .o_rdata (mem_q)
    );

    // Never-written or out-of-range registers read as zero
    assign reg_tag  = r_rd_ok ? reg_q : '0;
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cmd  <= i_in_cmd;
            r_rd   <= i_dst_reg;
            r_ra   <= i_src_a_reg;
            r_rb   <= i_src_b_reg;
            r_addr <= MEM_ADDR_BITS'(i_mem_address);
            if (i_in_cmd == CMD_WR_REG || i_in_cmd == CMD_WR_MEM) begin
                r_acc <= i_tag_value[TAG_BITS-1:0];
            end else begin
                r_acc <= '0;
            end
        end else begin
            case (i_cmd.cap)
                CAP_OR_REG:   r_acc <= r_acc | reg_tag;
                CAP_OR_MEM:   r_acc <= r_acc | mem_q;
                CAP_LOAD_REG: r_acc <= reg_tag;
                default:      ;
            endcase
        end
        if (i_cmd.reg_rd) begin
            r_rd_ok <= rd_in_range && r_valid[rd_idx[RA_W-1:0]];
        end
        if (i_cmd.out_load) begin
            r_out_tag <= r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (reg_we) begin
                r_valid[wr_idx[RA_W-1:0]] <= 1'b1;
            end
            if (i_cmd.clr_step) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.cmd      = r_cmd;
    assign o_stat.clr_last = &r_clr_cnt;
    assign o_stat.out_free = out_free;

    assign o_out_valid = r_out_valid;
    assign o_tag_out   = TAG_FIELD_W'(r_out_tag);
endmodule

>>> rtl/core/taint_propagation_unit.sv
`timescale 1ns / 1ps

// Taint propagation unit: shadow tags for NUM_REGS registers and each byte of memory.
// Input channel i_item carries one pre-classified instruction or direct tag access
// (cmd, register indexes, byte address, tag value); output channel o_result returns
// exactly one tag per item: the tag read, the tag written, or zero.
// Both channels are valid/ready; an item moves on a clock edge with both high.
// Reset (i_rst_n low, synchronous) clears all register tags at once through per-entry
// valid bits, then runs a clearing pass over all 2**MEM_ADDR_BITS bytes of the memory tag
// store (65536 by default), one byte per cycle; i_item.ready stays low until it ends.
// Items are taken one at a time. From acceptance, none, immediate moves and direct
// writes go straight to the write step; loads, stores, single-source moves, link, jump
// and direct reads first pass a read and a capture step; two-register arithmetic
// adds a second capture step; link then jump adds a link step and a second read
// and capture step. The next item can be accepted in the cycle the result first
// shows. The steps follow from the single read port of the register tag RAM and its
// registered read, plus a write step that writes back and loads the result register.
// A stalled receiver holds the result register; the unit still accepts one more item
// and works it through, then waits in its write step until the result register frees.
module taint_propagation_unit #(
    parameter int NUM_REGS      = tpu_pkg::NUM_REGS_DEF,
    parameter int MEM_ADDR_BITS = tpu_pkg::MEM_ADDR_BITS_DEF,
    parameter int TAG_BITS      = tpu_pkg::TAG_BITS_DEF,
    parameter int PC_INDEX      = tpu_pkg::PC_INDEX_DEF,
    parameter int LR_INDEX      = tpu_pkg::LR_INDEX_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tpu_in_if.sink    i_item,
    tpu_out_if.source o_result
);
    import tpu_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    logic     in_ready;

    // Sequencer: runs the clearing pass and walks each item through its read, capture, link and write steps
    tpu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_in_cmd   (i_item.cmd),
        .i_stat     (dp_stat),
        .o_in_ready (in_ready),
        .o_cmd      (dp_cmd)
    );

    // Tag stores, accumulator and result register
    tpu_dp #(
        .NUM_REGS      (NUM_REGS),
        .MEM_ADDR_BITS (MEM_ADDR_BITS),
        .TAG_BITS      (TAG_BITS),
        .PC_INDEX      (PC_INDEX),
        .LR_INDEX      (LR_INDEX)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_in_cmd      (i_item.cmd),
        .i_dst_reg     (i_item.dst_reg),
        .i_src_a_reg   (i_item.src_a_reg),
        .i_src_b_reg   (i_item.src_b_reg),
        .i_mem_address (i_item.mem_address),
        .i_tag_value   (i_item.tag_value),
        .i_out_ready   (o_result.ready),
        .o_out_valid   (o_result.valid),
        .o_tag_out     (o_result.tag_out)
    );

    assign i_item.ready = in_ready;
endmodule

>>> test/tpu_taint_checker.sv
`timescale 1ns / 1ps

// Watch both channels, keep a shadow copy of the register and memory tags,
// and compare every result against the oldest predicted tag.
module tpu_taint_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    tpu_in_if    item_mon,
    tpu_out_if   result_mon,
    output int   o_error_count,
    output int   o_pending
);
    import tpu_pkg::*;

    localparam int REG_COUNT = NUM_REGS_DEF;
    localparam int MEM_DEPTH = 1 << MEM_ADDR_BITS_DEF;
    localparam logic [TAG_FIELD_W-1:0] TAG_MASK = TAG_FIELD_W'((1 << TAG_BITS_DEF) - 1);
    localparam logic [ADDR_FIELD_W-1:0] ADDR_MASK = ADDR_FIELD_W'(MEM_DEPTH - 1);

    logic [TAG_FIELD_W-1:0] reg_tags [REG_COUNT];
    logic [TAG_FIELD_W-1:0] mem_tags [MEM_DEPTH];
    logic [TAG_FIELD_W-1:0] expected_tags [$];
    logic [TAG_FIELD_W-1:0] want_tag;

    initial begin
        o_error_count = 0;
        o_pending     = 0;
    end

    // Registers past the end read as zero and drop writes.
    function automatic logic [TAG_FIELD_W-1:0] reg_tag(input int idx);
        return (idx < REG_COUNT) ? (reg_tags[idx] & TAG_MASK) : '0;
    endfunction

    function automatic logic [TAG_FIELD_W-1:0] set_reg_tag(input int idx,
                                                            input logic [TAG_FIELD_W-1:0] tag);
        logic [TAG_FIELD_W-1:0] masked;
        masked = tag & TAG_MASK;
        if (idx < REG_COUNT) begin
            reg_tags[idx] = masked;
        end
        return masked;
    endfunction

    function automatic logic [TAG_FIELD_W-1:0] mem_tag(input logic [ADDR_FIELD_W-1:0] addr);
        return mem_tags[addr & ADDR_MASK] & TAG_MASK;
    endfunction

    function automatic logic [TAG_FIELD_W-1:0] set_mem_tag(input logic [ADDR_FIELD_W-1:0] addr,
                                                            input logic [TAG_FIELD_W-1:0] tag);
        logic [TAG_FIELD_W-1:0] masked;
        masked = tag & TAG_MASK;
        mem_tags[addr & ADDR_MASK] = masked;
        return masked;
    endfunction

    // Move tags the way the instruction moves data; return the tag reported.
    function automatic logic [TAG_FIELD_W-1:0] propagate_tag(
        input logic [CMD_W-1:0]        cmd,
        input logic [REG_FIELD_W-1:0]  rd,
        input logic [REG_FIELD_W-1:0]  ra,
        input logic [REG_FIELD_W-1:0]  rb,
        input logic [ADDR_FIELD_W-1:0] addr,
        input logic [TAG_FIELD_W-1:0]  tv
    );
        logic [TAG_FIELD_W-1:0] tag;
        int rd_idx;
        int ra_idx;
        int rb_idx;
        rd_idx = int'(rd);
        ra_idx = int'(ra);
        rb_idx = int'(rb);
        case (cmd)
            CMD_LOAD:                tag = set_reg_tag(rd_idx, mem_tag(addr));
            CMD_STORE:               tag = set_mem_tag(addr, reg_tag(rd_idx));
            CMD_MOV_REG, CMD_ARITH1: tag = set_reg_tag(rd_idx, reg_tag(ra_idx));
            CMD_MOV_IMM:             tag = set_reg_tag(rd_idx, '0);
            CMD_ARITH2:              tag = set_reg_tag(rd_idx, reg_tag(ra_idx) | reg_tag(rb_idx));
            CMD_LINK:                tag = set_reg_tag(LR_INDEX_DEF, reg_tag(PC_INDEX_DEF));
            CMD_LINK_JUMP: begin
                // link first, so a jump through LR sees the fresh tag
                void'(set_reg_tag(LR_INDEX_DEF, reg_tag(PC_INDEX_DEF)));
                tag = set_reg_tag(PC_INDEX_DEF, reg_tag(ra_idx));
            end
            CMD_JUMP:                tag = set_reg_tag(PC_INDEX_DEF, reg_tag(ra_idx));
            CMD_RD_REG:              tag = reg_tag(rd_idx);
            CMD_WR_REG:              tag = set_reg_tag(rd_idx, tv);
            CMD_RD_MEM:              tag = mem_tag(addr);
            CMD_WR_MEM:              tag = set_mem_tag(addr, tv);
            default:                 tag = '0;
        endcase
        return tag;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (reg_tags[r]) reg_tags[r] = '0;
            foreach (mem_tags[a]) mem_tags[a] = '0;
            expected_tags.delete();
        end else begin
            if (result_mon.valid && result_mon.ready) begin
                if (expected_tags.size() == 0) begin
                    $error("tag_out: result with no item outstanding, actual %0h",
                           result_mon.tag_out);
                    o_error_count = o_error_count + 1;
                end else begin
                    want_tag = expected_tags.pop_front();
                    if (result_mon.tag_out !== want_tag) begin
                        $error("tag_out mismatch: expected %0h, actual %0h",
                               want_tag, result_mon.tag_out);
                        o_error_count = o_error_count + 1;
                    end
                end
            end
            if (item_mon.valid && item_mon.ready) begin
                expected_tags.push_back(propagate_tag(item_mon.cmd, item_mon.dst_reg,
                                                      item_mon.src_a_reg, item_mon.src_b_reg,
                                                      item_mon.mem_address, item_mon.tag_value));
            end
        end
        o_pending = expected_tags.size();
    end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

// Drive the taint unit with a directed opening and a long random run, with
// random gaps on both channels; the checker beside the unit does the scoring.
module testbench;
    import tpu_pkg::*;

    localparam int CLK_HALF_NS     = 2;
    localparam int RESET_CYCLES    = 8;
    localparam int RANDOM_ITEMS    = 550;
    localparam int HOLD_OFF_AT     = 150;
    localparam int PAUSE_AT        = 350;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 20;
    // clearing pass plus a slow run of items, several times over
    localparam int CYCLE_LIMIT     = 600000;
    localparam int ADDR_POOL_SIZE  = 12;

    // spare command codes, expected to act as none
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 4'd14;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 4'd15;

    localparam logic [REG_FIELD_W-1:0] PC_REG = REG_FIELD_W'(PC_INDEX_DEF);
    localparam logic [REG_FIELD_W-1:0] LR_REG = REG_FIELD_W'(LR_INDEX_DEF);

    logic        clk;
    logic        rst_n;
    logic        calm;
    logic        hold_off_req;
    int          error_count;
    int          pending_count;
    int unsigned cycle_count;
    logic [ADDR_FIELD_W-1:0] addr_pool [ADDR_POOL_SIZE];

    tpu_in_if  item_if ();
    tpu_out_if result_if ();

    taint_propagation_unit uut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_if),
        .o_result (result_if)
    );

    tpu_taint_checker checker_inst (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .item_mon      (item_if),
        .result_mon    (result_if),
        .o_error_count (error_count),
        .o_pending     (pending_count)
    );

    always begin
        clk = 1'b1;
        #CLK_HALF_NS;
        clk = 1'b0;
        #CLK_HALF_NS;
    end

    initial cycle_count = 0;

    // Abort a hung run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Mostly no gap, some short ones, a few long; none during calm stretches.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm) return 0;
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input logic [CMD_W-1:0]        cmd,
                             input logic [REG_FIELD_W-1:0]  rd,
                             input logic [REG_FIELD_W-1:0]  ra,
                             input logic [REG_FIELD_W-1:0]  rb,
                             input logic [ADDR_FIELD_W-1:0] addr,
                             input logic [TAG_FIELD_W-1:0]  tv);
        item_if.valid       <= 1'b1;
        item_if.cmd         <= cmd;
        item_if.dst_reg     <= rd;
        item_if.src_a_reg   <= ra;
        item_if.src_b_reg   <= rb;
        item_if.mem_address <= addr;
        item_if.tag_value   <= tv;
        @(posedge clk);
        while (!item_if.ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Drop valid for a while and scramble the payload underneath.
    task automatic idle_gap(input int cycles);
        if (cycles > 0) begin
            item_if.valid <= 1'b0;
            repeat (cycles) begin
                item_if.cmd         <= CMD_W'($urandom);
                item_if.mem_address <= ADDR_FIELD_W'($urandom);
                item_if.tag_value   <= TAG_FIELD_W'($urandom);
                @(negedge clk);
            end
        end
    endtask

    // Most addresses come from a small pool so loads and reads hit stored tags.
    task automatic send_random_item();
        logic [ADDR_FIELD_W-1:0] addr;
        if ($urandom_range(0, 4) == 0) begin
            addr = ADDR_FIELD_W'($urandom);
        end else begin
            addr = addr_pool[$urandom_range(0, ADDR_POOL_SIZE - 1)];
        end
        send_item(CMD_W'($urandom_range(0, 15)),
                  REG_FIELD_W'($urandom_range(0, 15)),
                  REG_FIELD_W'($urandom_range(0, 15)),
                  REG_FIELD_W'($urandom_range(0, 15)),
                  addr,
                  TAG_FIELD_W'($urandom_range(0, 255)));
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        int stall;
        result_if.ready = 1'b0;
        @(negedge clk);
        forever begin
            if (hold_off_req) begin
                stall        = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end else begin
                stall = pick_gap();
            end
            if (stall > 0) begin
                result_if.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_if.ready <= 1'b1;
            @(negedge clk);
        end
    end

    // Sender and verdict.
    initial begin
        item_if.valid       = 1'b0;
        item_if.cmd         = '0;
        item_if.dst_reg     = '0;
        item_if.src_a_reg   = '0;
        item_if.src_b_reg   = '0;
        item_if.mem_address = '0;
        item_if.tag_value   = '0;
        rst_n               = 1'b0;
        calm                = 1'b0;
        hold_off_req        = 1'b0;

        addr_pool[0] = '0;
        addr_pool[1] = '1;
        for (int p = 2; p < ADDR_POOL_SIZE; p++) begin
            addr_pool[p] = ADDR_FIELD_W'($urandom);
        end

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Directed opening; the sender simply waits out the clearing pass.
        send_item(CMD_WR_REG,    4'd0,   4'd0,   4'd0, 16'h0000, 8'hFF);
        send_item(CMD_WR_REG,    PC_REG, 4'd0,   4'd0, 16'h0000, 8'hA5);
        send_item(CMD_RD_REG,    4'd0,   4'd0,   4'd0, 16'h0000, 8'h00);
        send_item(CMD_WR_MEM,    4'd0,   4'd0,   4'd0, 16'h0000, 8'h81);
        send_item(CMD_WR_MEM,    4'd0,   4'd0,   4'd0, 16'hFFFF, 8'h7E);
        send_item(CMD_RD_MEM,    4'd0,   4'd0,   4'd0, 16'hFFFF, 8'h00);
        // untouched byte still reads as cleared
        send_item(CMD_RD_MEM,    4'd0,   4'd0,   4'd0, 16'h1234, 8'h00);
        send_item(CMD_LOAD,      4'd3,   4'd0,   4'd0, 16'h0000, 8'h00);
        send_item(CMD_STORE,     PC_REG, 4'd0,   4'd0, 16'h8000, 8'h00);
        send_item(CMD_RD_MEM,    4'd0,   4'd0,   4'd0, 16'h8000, 8'h00);
        send_item(CMD_MOV_REG,   4'd4,   4'd3,   4'd0, 16'h0000, 8'h00);
        send_item(CMD_ARITH1,    4'd5,   PC_REG, 4'd0, 16'h0000, 8'h00);
        send_item(CMD_MOV_IMM,   4'd3,   4'd0,   4'd0, 16'h0000, 8'hFF);
        send_item(CMD_ARITH2,    4'd6,   4'd4,   4'd5, 16'h0000, 8'h00);
        send_item(CMD_ARITH2,    4'd7,   4'd7,   4'd7, 16'h0000, 8'h00);
        send_item(CMD_LINK,      4'd0,   4'd0,   4'd0, 16'h0000, 8'h00);
        send_item(CMD_RD_REG,    LR_REG, 4'd0,   4'd0, 16'h0000, 8'h00);
        send_item(CMD_WR_REG,    LR_REG, 4'd0,   4'd0, 16'h0000, 8'h3C);
        // link then jump through LR: the jump must see the fresh LR tag
        send_item(CMD_LINK_JUMP, 4'd0,   LR_REG, 4'd0, 16'h0000, 8'h00);
        send_item(CMD_LINK_JUMP, 4'd0,   PC_REG, 4'd0, 16'h0000, 8'h00);
        send_item(CMD_JUMP,      4'd0,   4'd0,   4'd0, 16'h0000, 8'h00);
        send_item(CMD_NONE,      4'd1,   4'd2,   4'd3, 16'hFFFF, 8'hFF);
        send_item(CMD_SPARE_LO,  4'd15,  4'd15,  4'd15, 16'hFFFF, 8'hFF);
        send_item(CMD_SPARE_HI,  4'd15,  4'd15,  4'd15, 16'hFFFF, 8'hFF);
        send_item(CMD_RD_REG,    PC_REG, 4'd0,   4'd0, 16'h0000, 8'h00);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            calm = ((i / 50) % 4 == 2);
            if (i == HOLD_OFF_AT) begin
                // keep offering items while the receiver holds off
                hold_off_req = 1'b1;
            end
            if (i == PAUSE_AT) begin
                item_if.valid <= 1'b0;
                wait (pending_count == 0);
                @(negedge clk);
            end
            idle_gap(pick_gap());
            send_random_item();
        end

        item_if.valid <= 1'b0;
        wait (pending_count == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/tpu_pkg.sv
rtl/core/tpu_if.sv
rtl/core/tpu_ram.sv
rtl/core/tpu_ctrl.sv
rtl/core/tpu_dp.sv
rtl/core/taint_propagation_unit.sv
test/tpu_taint_checker.sv
test/testbench.sv
